// File: sv/two_voice_tone_sequencer_defines.svh
// Assertion macros shared by the tone sequencer RTL.
`ifndef TWO_VOICE_TONE_SEQUENCER_DEFINES_SVH
`define TWO_VOICE_TONE_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TVTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define TVTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tvts_pkg.sv
// Types and constants of the two-voice tone sequencer.
`default_nettype none

package tvts_pkg;

  localparam int ADDR_W     = 10;
  localparam int DUR_W      = 8;
  localparam int PITCH_W    = 8;
  localparam int FRAME_W    = 8;
  localparam int MODE_W     = 3;
  localparam int CLK_W      = 17;
  localparam int TICK_W     = 16;
  localparam int ACC_W      = 17;
  localparam int DIVOUT_W   = 16;
  localparam int WORD_W     = DUR_W + PITCH_W;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int DIV_STEP_W = 5;

  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = 4;

  localparam logic [CLK_W-1:0]  CLOCK_CONST_RST = 17'd89489;
  localparam logic [TICK_W-1:0] TICK_NUM_RST    = 16'd1;
  localparam logic [TICK_W-1:0] TICK_DEN_RST    = 16'd1;

  localparam logic [CLK_W-1:0] DIV_BIAS = 17'd7;
  localparam logic [CLK_W-1:0] DIV_MAX  = 17'd65542;
  localparam logic [DIVOUT_W-1:0] DIV_TOP = 16'd65535;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD     = 3'd0,
    MODE_FRAME    = 3'd1,
    MODE_START_M  = 3'd2,
    MODE_STOP_M   = 3'd3,
    MODE_START_E  = 3'd4,
    MODE_TOGGLE   = 3'd5,
    MODE_ALL_OFF  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    REG_CLOCK_CONST = 2'd0,
    REG_TICK_NUM    = 2'd1,
    REG_TICK_DEN    = 2'd2,
    REG_MUSIC_OK    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DISPATCH,
    ST_OFF_MUSIC,
    ST_OFF_EFFECT,
    ST_FRAME,
    ST_ACC_CMP,
    ST_ACC_CLAMP,
    ST_V_CHECK,
    ST_V_WORD,
    ST_V_HEAD,
    ST_V_PLAY,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: sv/tvts_div.sv
// Bit-serial restoring divider: 17-bit clock constant over 8-bit pitch.
`default_nettype none

module tvts_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tvts_pkg::CLK_W-1:0]   dividend_i,
  input  wire logic [tvts_pkg::PITCH_W-1:0] divisor_i,
  output tvts_pkg::div_status_t            status_o,
  output logic      [tvts_pkg::CLK_W-1:0]   quotient_o
);
  import tvts_pkg::*;

  logic [CLK_W-1:0]      quo_q;
  logic [PITCH_W-1:0]    rem_q;
  logic [PITCH_W-1:0]    dvs_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [PITCH_W:0]      trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[CLK_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_STEP_W'(CLK_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[CLK_W-2:0], fits};
      rem_q <= fits ? PITCH_W'(trial - {1'b0, dvs_q}) : trial[PITCH_W-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

`default_nettype wire

// File: sv/two_voice_tone_sequencer.sv
// Top level: two-voice note sequencer with note store, tempo loop and tone divider.
//
//  port group          direction  beat marker             flow control
//  command (mode_i..)  in         start                   busy holds off
//  result (voice_o..)  out        res_strobe_o, 1 cycle   none, always taken
//  config (APB)        in/out     psel & penable          pready tied high
//
// A command passes ST_IDLE, ST_REDUCE (address folding by NOTE_DEPTH), ST_DISPATCH and
// ST_FINISH; all-off and toggle may add the OFF states. A tempo loop frame adds ST_FRAME,
// ST_ACC_CMP, ST_ACC_CLAMP, note fetches, bit-serial divides (one quotient bit a cycle).
// Each result waits one step in a holding register so last can be set.
// Results cannot be held off; busy is the only stall on the command side.
// Reset clears the sequencer state; the command item, held result data and note store are not reset.
`default_nettype none

`include "two_voice_tone_sequencer_defines.svh"

module two_voice_tone_sequencer #(
  parameter int NOTE_DEPTH     = 1024,
  parameter int CATCH_UP_LIMIT = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tvts_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [tvts_pkg::ADDR_W-1:0]     address_i,
  input  wire logic [tvts_pkg::DUR_W-1:0]      duration_i,
  input  wire logic [tvts_pkg::PITCH_W-1:0]    pitch_i,
  input  wire logic [tvts_pkg::FRAME_W-1:0]    frame_count_i,
  output logic                                 res_strobe_o,
  output logic                                 voice_o,
  output logic                                 tone_on_o,
  output logic      [tvts_pkg::DIVOUT_W-1:0]   divisor_o,
  output logic                                 last_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tvts_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [tvts_pkg::PDATA_W-1:0]    pwdata,
  output logic      [tvts_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);
  import tvts_pkg::*;

  localparam int IdxW  = $clog2(NOTE_DEPTH);
  localparam int WideW = (IdxW > ADDR_W) ? IdxW : ADDR_W;
  localparam int CntW  = $clog2(CATCH_UP_LIMIT + 1);
  localparam logic [WideW:0]   DepthW  = (WideW + 1)'(NOTE_DEPTH);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(NOTE_DEPTH - 1);
  localparam logic [FRAME_W-1:0] LimitF = FRAME_W'(CATCH_UP_LIMIT);

  // configuration
  logic [CLK_W-1:0]  clock_const_q;
  logic [TICK_W-1:0] tick_num_q;
  logic [TICK_W-1:0] tick_den_q;
  logic              music_ok_q;
  reg_e              reg_sel;
  logic              cfg_wr;

  // item and sequencer state
  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [WideW-1:0]   addr_q, addr_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic [PITCH_W-1:0] pitch_q, pitch_d;
  logic [FRAME_W-1:0] fc_q, fc_d;
  logic [IdxW-1:0]    m_ptr_q, m_ptr_d, m_head_q, m_head_d, e_ptr_q, e_ptr_d;
  logic [DUR_W-1:0]   m_left_q, m_left_d, e_left_q, e_left_d;
  logic               m_on_q, m_on_d, e_on_q, e_on_d, en_q, en_d;
  logic [ACC_W-1:0]   tempo_acc_q, tempo_acc_d;
  logic [FRAME_W-1:0] prev_q, prev_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               voice_q, voice_d;

  // result holding and output registers
  logic                  pend_valid_q, pend_voice_q, pend_on_q;
  logic [DIVOUT_W-1:0]   pend_div_q;
  logic [RES_CNT_W-1:0]  cnt_q;
  logic                  strobe_q, out_voice_q, out_on_q, out_last_q;
  logic [DIVOUT_W-1:0]   out_div_q;

  // note store
  logic [WORD_W-1:0] note_mem [NOTE_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_addr;

  // datapath helpers
  logic               accept;
  logic               addr_ge, acc_ge;
  logic [ACC_W-1:0]   tick_den_ext;
  logic [IdxW-1:0]    addr_idx, cur_ptr, nxt_ptr;
  logic               cur_on;
  logic [DUR_W-1:0]   cur_left, left_dec;
  logic [DUR_W-1:0]   w_dur;
  logic [PITCH_W-1:0] w_pitch;
  logic [FRAME_W-1:0] frame_gap;
  logic               emit_req, emit_voice, emit_on, flush;
  logic [DIVOUT_W-1:0] emit_div, div_sat;
  logic               div_start;
  div_status_t        div_stat;
  logic [CLK_W-1:0]   quotient;

  tvts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_const_q),
    .divisor_i  (w_pitch),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_const_q <= CLOCK_CONST_RST;
      tick_num_q    <= TICK_NUM_RST;
      tick_den_q    <= TICK_DEN_RST;
      music_ok_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CLOCK_CONST: clock_const_q <= pwdata[CLK_W-1:0];
        REG_TICK_NUM:    tick_num_q    <= pwdata[TICK_W-1:0];
        REG_TICK_DEN:    tick_den_q    <= pwdata[TICK_W-1:0];
        REG_MUSIC_OK:    music_ok_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CLOCK_CONST: prdata = PDATA_W'(clock_const_q);
      REG_TICK_NUM:    prdata = PDATA_W'(tick_num_q);
      REG_TICK_DEN:    prdata = PDATA_W'(tick_den_q);
      REG_MUSIC_OK:    prdata = PDATA_W'(music_ok_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- shared datapath terms ----------------
  assign busy         = state_q != ST_IDLE;
  assign accept       = start && !busy;
  assign addr_ge      = {1'b0, addr_q} >= DepthW;
  assign addr_idx     = addr_q[IdxW-1:0];
  assign tick_den_ext = {1'b0, tick_den_q};
  assign acc_ge       = tempo_acc_q >= tick_den_ext;
  assign cur_on       = voice_q ? e_on_q : m_on_q;
  assign cur_left     = voice_q ? e_left_q : m_left_q;
  assign cur_ptr      = voice_q ? e_ptr_q : m_ptr_q;
  assign left_dec     = (cur_left != '0) ? cur_left - 1'b1 : '0;
  assign nxt_ptr      = (cur_ptr == LastIdx) ? '0 : cur_ptr + 1'b1;
  assign w_dur        = rdata_q[WORD_W-1:PITCH_W];
  assign w_pitch      = rdata_q[PITCH_W-1:0];
  assign frame_gap    = fc_q - prev_q;

  always_comb begin
    if (quotient > DIV_MAX)       div_sat = DIV_TOP;
    else if (quotient < DIV_BIAS) div_sat = '0;
    else                          div_sat = DIVOUT_W'(quotient - DIV_BIAS);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = ST_REDUCE;
      ST_REDUCE:   if (!addr_ge) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (mode_q)
          MODE_FRAME:   state_d = (en_q && (m_on_q || e_on_q)) ? ST_FRAME : ST_FINISH;
          MODE_TOGGLE:  state_d = en_q ? ST_OFF_MUSIC : ST_FINISH;
          MODE_ALL_OFF: state_d = ST_OFF_MUSIC;
          default:      state_d = ST_FINISH;
        endcase
      end
      ST_OFF_MUSIC:  state_d = ST_OFF_EFFECT;
      ST_OFF_EFFECT: state_d = ST_FINISH;
      ST_FRAME:      state_d = (n_q == '0) ? ST_FINISH : ST_ACC_CMP;
      ST_ACC_CMP:    state_d = acc_ge ? ST_ACC_CLAMP : ST_FRAME;
      ST_ACC_CLAMP:  state_d = ST_V_CHECK;
      ST_V_CHECK: begin
        if (cur_on && left_dec == '0) state_d = ST_V_WORD;
        else state_d = voice_q ? ST_FRAME : ST_V_CHECK;
      end
      ST_V_WORD: begin
        if (w_dur != '0) state_d = ST_V_PLAY;
        else if (!voice_q) state_d = ST_V_HEAD;
        else state_d = ST_FRAME;
      end
      ST_V_HEAD: begin
        if (w_dur != '0) state_d = ST_V_PLAY;
        else state_d = ST_V_CHECK;
      end
      ST_V_PLAY: begin
        if (w_pitch != '0) state_d = ST_DIV;
        else state_d = voice_q ? ST_FRAME : ST_V_CHECK;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = voice_q ? ST_FRAME : ST_V_CHECK;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    mode_d      = mode_q;
    addr_d      = addr_q;
    dur_d       = dur_q;
    pitch_d     = pitch_q;
    fc_d        = fc_q;
    m_ptr_d     = m_ptr_q;
    m_head_d    = m_head_q;
    e_ptr_d     = e_ptr_q;
    m_left_d    = m_left_q;
    e_left_d    = e_left_q;
    m_on_d      = m_on_q;
    e_on_d      = e_on_q;
    en_d        = en_q;
    tempo_acc_d = tempo_acc_q;
    prev_d      = prev_q;
    n_d         = n_q;
    voice_d     = voice_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = cur_ptr;
    emit_req    = 1'b0;
    emit_voice  = voice_q;
    emit_on     = 1'b0;
    emit_div    = '0;
    div_start   = 1'b0;
    flush       = 1'b0;

    // a finished music voice hands the tick to the effect voice
    if (!voice_q && state_d == ST_V_CHECK && state_q != ST_ACC_CLAMP) voice_d = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d  = mode_e'(mode_i);
          addr_d  = WideW'(address_i);
          dur_d   = duration_i;
          pitch_d = pitch_i;
          fc_d    = frame_count_i;
        end
      end
      ST_REDUCE: begin
        if (addr_ge) addr_d = WideW'({1'b0, addr_q} - DepthW);
      end
      ST_DISPATCH: begin
        case (mode_q)
          MODE_LOAD: begin
            mem_we   = 1'b1;
            mem_addr = addr_idx;
          end
          MODE_FRAME: begin
            prev_d = fc_q;
            n_d    = (frame_gap > LimitF) ? CntW'(CATCH_UP_LIMIT) : CntW'(frame_gap);
          end
          MODE_START_M: begin
            if (!music_ok_q) begin
              m_on_d     = 1'b0;
              emit_req   = 1'b1;
              emit_voice = 1'b0;
            end else begin
              m_head_d    = addr_idx;
              m_ptr_d     = addr_idx;
              m_on_d      = 1'b1;
              m_left_d    = '0;
              tempo_acc_d = '0;
            end
          end
          MODE_STOP_M: begin
            m_on_d     = 1'b0;
            emit_req   = 1'b1;
            emit_voice = 1'b0;
          end
          MODE_START_E: begin
            if (en_q && music_ok_q) begin
              e_ptr_d  = addr_idx;
              e_on_d   = 1'b1;
              e_left_d = '0;
            end
          end
          MODE_TOGGLE: en_d = !en_q;
          default: ;
        endcase
      end
      ST_OFF_MUSIC: begin
        emit_req   = 1'b1;
        emit_voice = 1'b0;
      end
      ST_OFF_EFFECT: begin
        emit_req   = 1'b1;
        emit_voice = 1'b1;
        m_on_d     = 1'b0;
        e_on_d     = 1'b0;
      end
      ST_FRAME: begin
        if (n_q != '0) begin
          n_d         = n_q - 1'b1;
          tempo_acc_d = tempo_acc_q + ACC_W'(tick_num_q);
        end
      end
      ST_ACC_CMP: begin
        if (acc_ge) tempo_acc_d = tempo_acc_q - tick_den_ext;
      end
      ST_ACC_CLAMP: begin
        voice_d = 1'b0;
        if (acc_ge) tempo_acc_d = (tick_den_q == '0) ? '0 : tick_den_ext - 1'b1;
      end
      ST_V_CHECK: begin
        if (cur_on) begin
          if (voice_q) e_left_d = left_dec;
          else         m_left_d = left_dec;
          if (left_dec == '0) mem_re = 1'b1;
        end
      end
      ST_V_WORD: begin
        if (w_dur == '0) begin
          if (!voice_q) begin
            m_ptr_d  = m_head_q;
            mem_re   = 1'b1;
            mem_addr = m_head_q;
          end else begin
            e_on_d   = 1'b0;
            emit_req = 1'b1;
          end
        end
      end
      ST_V_HEAD: begin
        if (w_dur == '0) begin
          m_on_d   = 1'b0;
          emit_req = 1'b1;
        end
      end
      ST_V_PLAY: begin
        if (voice_q) begin
          e_left_d = w_dur;
          e_ptr_d  = nxt_ptr;
        end else begin
          m_left_d = w_dur;
          m_ptr_d  = nxt_ptr;
        end
        if (w_pitch == '0) emit_req  = 1'b1;
        else               div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          emit_req = 1'b1;
          emit_on  = 1'b1;
          emit_div = div_sat;
        end
      end
      ST_FINISH: flush = 1'b1;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_ptr_q     <= '0;
      m_head_q    <= '0;
      e_ptr_q     <= '0;
      m_left_q    <= '0;
      e_left_q    <= '0;
      m_on_q      <= 1'b0;
      e_on_q      <= 1'b0;
      en_q        <= 1'b1;
      tempo_acc_q <= '0;
      prev_q      <= '0;
      n_q         <= '0;
      voice_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_ptr_q     <= m_ptr_d;
      m_head_q    <= m_head_d;
      e_ptr_q     <= e_ptr_d;
      m_left_q    <= m_left_d;
      e_left_q    <= e_left_d;
      m_on_q      <= m_on_d;
      e_on_q      <= e_on_d;
      en_q        <= en_d;
      tempo_acc_q <= tempo_acc_d;
      prev_q      <= prev_d;
      n_q         <= n_d;
      voice_q     <= voice_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    addr_q  <= addr_d;
    dur_q   <= dur_d;
    pitch_q <= pitch_d;
    fc_q    <= fc_d;
  end

  // note store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) note_mem[mem_addr] <= {dur_q, pitch_q};
    if (mem_re) rdata_q <= note_mem[mem_addr];
  end

  // result holding stage: a beat leaves only once the next is known or the item ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      strobe_q <= 1'b0;
      if (accept) cnt_q <= '0;
      if (flush) begin
        strobe_q     <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end else if (emit_req && cnt_q < RES_CNT_W'(MAX_RESULTS)) begin
        strobe_q     <= pend_valid_q;
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flush) begin
      out_voice_q <= pend_voice_q;
      out_on_q    <= pend_on_q;
      out_div_q   <= pend_div_q;
      out_last_q  <= 1'b1;
    end else if (emit_req && cnt_q < RES_CNT_W'(MAX_RESULTS)) begin
      out_voice_q  <= pend_voice_q;
      out_on_q     <= pend_on_q;
      out_div_q    <= pend_div_q;
      out_last_q   <= 1'b0;
      pend_voice_q <= emit_voice;
      pend_on_q    <= emit_on;
      pend_div_q   <= emit_div;
    end
  end

  assign res_strobe_o = strobe_q;
  assign voice_o      = out_voice_q;
  assign tone_on_o    = out_on_q;
  assign divisor_o    = out_div_q;
  assign last_o       = out_last_q;

  // ---------------- assertions ----------------
  `TVTS_ASSERT_NXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `TVTS_ASSERT_IMP(a_strobe_in_item, res_strobe_o, $past(state_q) != ST_IDLE, "result beat outside a command")
  `TVTS_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= RES_CNT_W'(MAX_RESULTS), "result count above limit")
  `TVTS_ASSERT_NXT(a_acc_bounded, state_q == ST_ACC_CLAMP, (tempo_acc_q < tick_den_ext) || (tempo_acc_q == '0), "tempo accumulator not below threshold after tick")
  `TVTS_ASSERT_IMP(a_div_done, div_stat.done, state_q == ST_DIV, "divider finished outside divide wait")

endmodule

`default_nettype wire
